[hw/rtl/cfs_pkg.sv]
package cfs_pkg;

    localparam int MAX_DIM = 8;
    localparam int IDX_W   = 3;
    localparam int DIM_W   = 4;
    localparam int ADDR_W  = 6;
    localparam int DATA_W  = 32;

    localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7fff_ffff;
    localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

    typedef enum logic [2:0] {
        OP_LOAD_M = 3'd0,
        OP_LOAD_V = 3'd1,
        OP_FACTOR = 3'd2,
        OP_SOLVE  = 3'd3,
        OP_FWD    = 3'd4,
        OP_QFORM  = 3'd5,
        OP_READ   = 3'd6
    } cfs_op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_PIVOT = 2'd1,
        ST_DIV0  = 2'd2
    } cfs_status_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_ACC_RAM,
        DP_ACC_VEC,
        DP_ACC_ZERO,
        DP_OPA_RAM,
        DP_MUL_AR,
        DP_MUL_RR,
        DP_MUL_RV,
        DP_MUL_VV,
        DP_ACC_SUB,
        DP_ACC_ADD,
        DP_DIV,
        DP_SQRT
    } cfs_dp_op_t;

    typedef enum logic [1:0] {
        WSEL_DATA,
        WSEL_ZERO,
        WSEL_RES
    } cfs_wsel_t;

    typedef enum logic [1:0] {
        OSEL_ZERO,
        OSEL_VEC,
        OSEL_ACC,
        OSEL_RAM
    } cfs_osel_t;

    typedef enum logic [5:0] {
        S_IDLE,
        S_F_J, S_F_JJ, S_F_DK, S_F_DK_M, S_F_DK_S, S_F_PIV, S_F_ZC, S_F_SQ_W,
        S_F_I, S_F_I_LD, S_F_IK, S_F_IK_A, S_F_IK_B, S_F_IK_S, S_F_DEN, S_F_DIV_W,
        S_F_CJ, S_F_CI,
        S_FI, S_FJ, S_FJ_M, S_FJ_S, S_FDEN, S_FDIV_W,
        S_BI, S_BJ, S_BJ_M, S_BJ_S, S_BDEN, S_BDIV_W,
        S_Q_I, S_Q_S,
        S_EMIT_ZERO, S_EMIT_ACC, S_EMIT_RD, S_EMIT_VEC
    } cfs_state_t;

    typedef struct packed {
        cfs_dp_op_t        op;
        logic              ram_we;
        logic [ADDR_W-1:0] ram_addr;
        cfs_wsel_t         ram_wsel;
        logic              vec_we;
        logic [IDX_W-1:0]  vidx;
        cfs_wsel_t         vec_wsel;
        logic              out_load;
        cfs_osel_t         out_sel;
        logic [IDX_W-1:0]  out_index;
        logic              out_last;
        logic              pivot_clr;
        logic              pivot_set;
        logic              dz_clr;
    } cfs_cmd_t;

    typedef struct packed {
        logic busy;
        logic acc_nonpos;
        logic out_busy;
    } cfs_stat_t;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] x);
        logic signed [DATA_W-1:0] r;
        if (x > 64'sh0000_0000_7fff_ffff)
        begin
            r = Q_MAX;
        end
        else if (x < -64'sh0000_0000_8000_0000)
        begin
            r = Q_MIN;
        end
        else
        begin
            r = x[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

[hw/rtl/cfs_ram.sv]
module cfs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

[hw/rtl/cfs_datapath.sv]
module cfs_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  cfs_pkg::cfs_cmd_t               cmd,
    output cfs_pkg::cfs_stat_t              stat,
    input  logic signed [cfs_pkg::DATA_W-1:0] data_value,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic signed [cfs_pkg::DATA_W-1:0] result_value,
    output logic [cfs_pkg::IDX_W-1:0]       result_index,
    output logic                            last_of_run,
    output logic [1:0]                      status
);

    logic signed [cfs_pkg::DATA_W-1:0] ram_rdata;
    logic [cfs_pkg::DATA_W-1:0]        ram_q;
    logic [cfs_pkg::DATA_W-1:0]        ram_wdata;
    logic signed [cfs_pkg::DATA_W-1:0] vec_reg [cfs_pkg::MAX_DIM];
    logic signed [cfs_pkg::DATA_W-1:0] vec_rd;
    logic signed [cfs_pkg::DATA_W-1:0] vec_wdata;

    logic signed [63:0]                acc_reg, acc_next;
    logic signed [cfs_pkg::DATA_W-1:0] opa_reg;
    logic signed [63:0]                prod_reg;
    logic signed [cfs_pkg::DATA_W-1:0] mul_a, mul_b;
    logic                              mul_en;

    logic                              pivot_reg, dz_reg, dz_next;
    logic                              busy_reg, busy_next;
    logic                              sqrt_mode_reg, sqrt_mode_next;
    logic                              neg_reg, neg_next;
    logic [5:0]                        cnt_reg, cnt_next;
    logic [47:0]                       dvd_reg, dvd_next;
    logic [32:0]                       rem_reg, rem_next;
    logic [31:0]                       dsr_reg, dsr_next;
    logic [47:0]                       q_reg, q_next;
    logic [47:0]                       bit_reg, bit_next;
    logic signed [cfs_pkg::DATA_W-1:0] res_reg, res_next;

    logic signed [cfs_pkg::DATA_W-1:0] sat_acc;
    logic [32:0]                       rem_sh;
    logic [47:0]                       trial;

    logic                              out_valid_reg;
    logic signed [cfs_pkg::DATA_W-1:0] out_value_reg;
    logic [cfs_pkg::IDX_W-1:0]         out_index_reg;
    logic                              out_last_reg;
    logic [1:0]                        out_status_reg;
    logic signed [cfs_pkg::DATA_W-1:0] out_value_next;

    cfs_ram #(
        .WIDTH(cfs_pkg::DATA_W),
        .DEPTH(cfs_pkg::MAX_DIM * cfs_pkg::MAX_DIM)
    ) u_matrix (
        .clk  (clk),
        .we   (cmd.ram_we),
        .addr (cmd.ram_addr),
        .wdata(ram_wdata),
        .rdata(ram_q)
    );

    assign ram_rdata = ram_q;
    assign vec_rd    = vec_reg[cmd.vidx];
    assign sat_acc   = cfs_pkg::sat32(acc_reg);

    always_comb
    begin
        unique case (cmd.ram_wsel)
            cfs_pkg::WSEL_DATA: ram_wdata = data_value;
            cfs_pkg::WSEL_RES:  ram_wdata = res_reg;
            default:            ram_wdata = '0;
        endcase
        unique case (cmd.vec_wsel)
            cfs_pkg::WSEL_DATA: vec_wdata = data_value;
            cfs_pkg::WSEL_RES:  vec_wdata = res_reg;
            default:            vec_wdata = '0;
        endcase
    end

    always_comb
    begin
        mul_en = 1'b1;
        mul_a  = ram_rdata;
        mul_b  = ram_rdata;
        unique case (cmd.op)
            cfs_pkg::DP_MUL_AR:
            begin
                mul_a = opa_reg;
            end
            cfs_pkg::DP_MUL_RR:
            begin
                mul_b = ram_rdata;
            end
            cfs_pkg::DP_MUL_RV:
            begin
                mul_b = vec_rd;
            end
            cfs_pkg::DP_MUL_VV:
            begin
                mul_a = vec_rd;
                mul_b = vec_rd;
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        acc_next = acc_reg;
        unique case (cmd.op)
            cfs_pkg::DP_ACC_RAM:  acc_next = 64'(ram_rdata);
            cfs_pkg::DP_ACC_VEC:  acc_next = 64'(vec_rd);
            cfs_pkg::DP_ACC_ZERO: acc_next = '0;
            cfs_pkg::DP_ACC_SUB:  acc_next = acc_reg - (prod_reg >>> 16);
            cfs_pkg::DP_ACC_ADD:  acc_next = acc_reg + (prod_reg >>> 16);
            default:              acc_next = acc_reg;
        endcase
    end

    // shared iterative unit: restoring divide, or bitwise square root
    always_comb
    begin
        busy_next      = busy_reg;
        sqrt_mode_next = sqrt_mode_reg;
        neg_next       = neg_reg;
        cnt_next       = cnt_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        dsr_next       = dsr_reg;
        q_next         = q_reg;
        bit_next       = bit_reg;
        res_next       = res_reg;
        dz_next        = dz_reg;
        rem_sh         = {rem_reg[31:0], dvd_reg[47]};
        trial          = q_reg + bit_reg;
        if (cmd.dz_clr)
        begin
            dz_next = 1'b0;
        end
        if (busy_reg)
        begin
            cnt_next = cnt_reg - 6'd1;
            if (sqrt_mode_reg)
            begin
                if (dvd_reg >= trial)
                begin
                    dvd_next = dvd_reg - trial;
                    q_next   = (q_reg >> 1) + bit_reg;
                end
                else
                begin
                    q_next = q_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                if (cnt_reg == '0)
                begin
                    busy_next = 1'b0;
                    res_next  = q_next[31:0];
                end
            end
            else
            begin
                dvd_next = {dvd_reg[46:0], 1'b0};
                if (rem_sh >= {1'b0, dsr_reg})
                begin
                    rem_next = rem_sh - {1'b0, dsr_reg};
                    q_next   = {q_reg[46:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh;
                    q_next   = {q_reg[46:0], 1'b0};
                end
                if (cnt_reg == '0)
                begin
                    busy_next = 1'b0;
                    if (neg_reg)
                    begin
                        if (q_next > 48'h0000_8000_0000)
                        begin
                            res_next = cfs_pkg::Q_MIN;
                        end
                        else
                        begin
                            res_next = -q_next[31:0];
                        end
                    end
                    else if (q_next > 48'h0000_7fff_ffff)
                    begin
                        res_next = cfs_pkg::Q_MAX;
                    end
                    else
                    begin
                        res_next = q_next[31:0];
                    end
                end
            end
        end
        else if (cmd.op == cfs_pkg::DP_DIV)
        begin
            if (ram_rdata == '0)
            begin
                dz_next = 1'b1;
                if (sat_acc > 0)
                begin
                    res_next = cfs_pkg::Q_MAX;
                end
                else if (sat_acc < 0)
                begin
                    res_next = cfs_pkg::Q_MIN;
                end
                else
                begin
                    res_next = '0;
                end
            end
            else
            begin
                busy_next      = 1'b1;
                sqrt_mode_next = 1'b0;
                neg_next       = sat_acc[31] ^ ram_rdata[31];
                dvd_next       = {(sat_acc[31] ? -sat_acc : sat_acc), 16'h0000};
                dsr_next       = ram_rdata[31] ? -ram_rdata : ram_rdata;
                rem_next       = '0;
                q_next         = '0;
                cnt_next       = 6'd47;
            end
        end
        else if (cmd.op == cfs_pkg::DP_SQRT)
        begin
            busy_next      = 1'b1;
            sqrt_mode_next = 1'b1;
            dvd_next       = {sat_acc, 16'h0000};
            q_next         = '0;
            bit_next       = 48'h4000_0000_0000;
            cnt_next       = 6'd23;
        end
    end

    always_comb
    begin
        unique case (cmd.out_sel)
            cfs_pkg::OSEL_VEC: out_value_next = vec_rd;
            cfs_pkg::OSEL_ACC: out_value_next = sat_acc;
            cfs_pkg::OSEL_RAM: out_value_next = ram_rdata;
            default:           out_value_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pivot_reg     <= 1'b0;
            dz_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            dz_reg   <= dz_next;
            if (cmd.pivot_clr)
            begin
                pivot_reg <= 1'b0;
            end
            else if (cmd.pivot_set)
            begin
                pivot_reg <= 1'b1;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg       <= acc_next;
        sqrt_mode_reg <= sqrt_mode_next;
        neg_reg       <= neg_next;
        cnt_reg       <= cnt_next;
        dvd_reg       <= dvd_next;
        rem_reg       <= rem_next;
        dsr_reg       <= dsr_next;
        q_reg         <= q_next;
        bit_reg       <= bit_next;
        res_reg       <= res_next;
        if (cmd.op == cfs_pkg::DP_OPA_RAM)
        begin
            opa_reg <= ram_rdata;
        end
        if (mul_en)
        begin
            prod_reg <= mul_a * mul_b;
        end
        if (cmd.vec_we)
        begin
            vec_reg[cmd.vidx] <= vec_wdata;
        end
        if (cmd.out_load)
        begin
            out_value_reg <= out_value_next;
            out_index_reg <= cmd.out_index;
            out_last_reg  <= cmd.out_last;
            if (dz_reg)
            begin
                out_status_reg <= cfs_pkg::ST_DIV0;
            end
            else if (pivot_reg)
            begin
                out_status_reg <= cfs_pkg::ST_PIVOT;
            end
            else
            begin
                out_status_reg <= cfs_pkg::ST_OK;
            end
        end
    end

    assign stat.busy       = busy_reg;
    assign stat.acc_nonpos = (acc_reg <= 0);
    assign stat.out_busy   = out_valid_reg && !out_ready;

    assign out_valid    = out_valid_reg;
    assign result_value = out_value_reg;
    assign result_index = out_index_reg;
    assign last_of_run  = out_last_reg;
    assign status       = out_status_reg;

endmodule

[hw/rtl/cfs_controller.sv]
module cfs_controller (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [cfs_pkg::DIM_W-1:0]  cfg_wr_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [2:0]                 operation,
    input  logic [cfs_pkg::IDX_W-1:0]  row_index,
    input  logic [cfs_pkg::IDX_W-1:0]  col_index,
    input  cfs_pkg::cfs_stat_t         stat,
    output cfs_pkg::cfs_cmd_t          cmd
);

    cfs_pkg::cfs_state_t         state_reg, state_next;
    logic [cfs_pkg::DIM_W-1:0]   size_reg;
    logic [cfs_pkg::DIM_W-1:0]   i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [cfs_pkg::DIM_W-1:0]   p, b;
    cfs_pkg::cfs_op_t            op_reg, op_next;
    logic [cfs_pkg::IDX_W-1:0]   r_reg, c_reg;
    logic [cfs_pkg::IDX_W-1:0]   ii, jj, kk, bb;

    always_comb
    begin
        if (size_reg == '0)
        begin
            p = cfs_pkg::DIM_W'(1);
        end
        else if (size_reg > cfs_pkg::DIM_W'(cfs_pkg::MAX_DIM))
        begin
            p = cfs_pkg::DIM_W'(cfs_pkg::MAX_DIM);
        end
        else
        begin
            p = size_reg;
        end
    end

    assign b  = i_reg - cfs_pkg::DIM_W'(1);
    assign ii = i_reg[cfs_pkg::IDX_W-1:0];
    assign jj = j_reg[cfs_pkg::IDX_W-1:0];
    assign kk = k_reg[cfs_pkg::IDX_W-1:0];
    assign bb = b[cfs_pkg::IDX_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cfs_pkg::S_IDLE;
            size_reg  <= cfs_pkg::DIM_W'(cfs_pkg::MAX_DIM);
            op_reg    <= cfs_pkg::OP_LOAD_M;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            if (cfg_wr_en)
            begin
                size_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg <= i_next;
        j_reg <= j_next;
        k_reg <= k_next;
        if (in_valid && in_ready)
        begin
            r_reg <= row_index;
            c_reg <= col_index;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        k_next        = k_reg;
        op_next       = op_reg;
        in_ready      = 1'b0;
        cmd.op        = cfs_pkg::DP_NOP;
        cmd.ram_we    = 1'b0;
        cmd.ram_addr  = {ii, jj};
        cmd.ram_wsel  = cfs_pkg::WSEL_ZERO;
        cmd.vec_we    = 1'b0;
        cmd.vidx      = ii;
        cmd.vec_wsel  = cfs_pkg::WSEL_RES;
        cmd.out_load  = 1'b0;
        cmd.out_sel   = cfs_pkg::OSEL_ZERO;
        cmd.out_index = '0;
        cmd.out_last  = 1'b1;
        cmd.pivot_clr = 1'b0;
        cmd.pivot_set = 1'b0;
        cmd.dz_clr    = 1'b0;

        unique case (state_reg)
            cfs_pkg::S_IDLE:
            begin
                in_ready     = 1'b1;
                cmd.ram_addr = {row_index, col_index};
                cmd.vidx     = row_index;
                if (in_valid)
                begin
                    op_next = cfs_pkg::cfs_op_t'(operation);
                    unique case (operation)
                        cfs_pkg::OP_LOAD_M:
                        begin
                            cmd.ram_we   = 1'b1;
                            cmd.ram_wsel = cfs_pkg::WSEL_DATA;
                        end
                        cfs_pkg::OP_LOAD_V:
                        begin
                            cmd.vec_we   = 1'b1;
                            cmd.vec_wsel = cfs_pkg::WSEL_DATA;
                        end
                        cfs_pkg::OP_FACTOR:
                        begin
                            cmd.pivot_clr = 1'b1;
                            cmd.dz_clr    = 1'b1;
                            j_next        = '0;
                            state_next    = cfs_pkg::S_F_J;
                        end
                        cfs_pkg::OP_SOLVE, cfs_pkg::OP_FWD, cfs_pkg::OP_QFORM:
                        begin
                            cmd.dz_clr = 1'b1;
                            i_next     = '0;
                            state_next = cfs_pkg::S_FI;
                        end
                        cfs_pkg::OP_READ:
                        begin
                            cmd.dz_clr = 1'b1;
                            state_next = cfs_pkg::S_EMIT_RD;
                        end
                        default:
                        begin
                            state_next = cfs_pkg::S_IDLE;
                        end
                    endcase
                end
            end

            cfs_pkg::S_F_J:
            begin
                cmd.ram_addr = {jj, jj};
                if (j_reg == p)
                begin
                    j_next     = '0;
                    state_next = cfs_pkg::S_F_CJ;
                end
                else
                begin
                    state_next = cfs_pkg::S_F_JJ;
                end
            end
            cfs_pkg::S_F_JJ:
            begin
                cmd.op     = cfs_pkg::DP_ACC_RAM;
                i_next     = '0;
                state_next = cfs_pkg::S_F_DK;
            end
            cfs_pkg::S_F_DK:
            begin
                cmd.ram_addr = {jj, ii};
                state_next   = (i_reg == j_reg) ? cfs_pkg::S_F_PIV : cfs_pkg::S_F_DK_M;
            end
            cfs_pkg::S_F_DK_M:
            begin
                cmd.op     = cfs_pkg::DP_MUL_RR;
                state_next = cfs_pkg::S_F_DK_S;
            end
            cfs_pkg::S_F_DK_S:
            begin
                cmd.op     = cfs_pkg::DP_ACC_SUB;
                i_next     = i_reg + cfs_pkg::DIM_W'(1);
                state_next = cfs_pkg::S_F_DK;
            end
            cfs_pkg::S_F_PIV:
            begin
                if (stat.acc_nonpos)
                begin
                    cmd.pivot_set = 1'b1;
                    i_next        = j_reg;
                    state_next    = cfs_pkg::S_F_ZC;
                end
                else
                begin
                    cmd.op     = cfs_pkg::DP_SQRT;
                    state_next = cfs_pkg::S_F_SQ_W;
                end
            end
            cfs_pkg::S_F_ZC:
            begin
                if (i_reg == p)
                begin
                    j_next     = j_reg + cfs_pkg::DIM_W'(1);
                    state_next = cfs_pkg::S_F_J;
                end
                else
                begin
                    cmd.ram_we   = 1'b1;
                    cmd.ram_addr = {ii, jj};
                    i_next       = i_reg + cfs_pkg::DIM_W'(1);
                end
            end
            cfs_pkg::S_F_SQ_W:
            begin
                if (!stat.busy)
                begin
                    cmd.ram_we   = 1'b1;
                    cmd.ram_addr = {jj, jj};
                    cmd.ram_wsel = cfs_pkg::WSEL_RES;
                    i_next       = j_reg + cfs_pkg::DIM_W'(1);
                    state_next   = cfs_pkg::S_F_I;
                end
            end
            cfs_pkg::S_F_I:
            begin
                cmd.ram_addr = {ii, jj};
                if (i_reg == p)
                begin
                    j_next     = j_reg + cfs_pkg::DIM_W'(1);
                    state_next = cfs_pkg::S_F_J;
                end
                else
                begin
                    state_next = cfs_pkg::S_F_I_LD;
                end
            end
            cfs_pkg::S_F_I_LD:
            begin
                cmd.op     = cfs_pkg::DP_ACC_RAM;
                k_next     = '0;
                state_next = cfs_pkg::S_F_IK;
            end
            cfs_pkg::S_F_IK:
            begin
                if (k_reg == j_reg)
                begin
                    cmd.ram_addr = {jj, jj};
                    state_next   = cfs_pkg::S_F_DEN;
                end
                else
                begin
                    cmd.ram_addr = {ii, kk};
                    state_next   = cfs_pkg::S_F_IK_A;
                end
            end
            cfs_pkg::S_F_IK_A:
            begin
                cmd.op       = cfs_pkg::DP_OPA_RAM;
                cmd.ram_addr = {jj, kk};
                state_next   = cfs_pkg::S_F_IK_B;
            end
            cfs_pkg::S_F_IK_B:
            begin
                cmd.op     = cfs_pkg::DP_MUL_AR;
                state_next = cfs_pkg::S_F_IK_S;
            end
            cfs_pkg::S_F_IK_S:
            begin
                cmd.op     = cfs_pkg::DP_ACC_SUB;
                k_next     = k_reg + cfs_pkg::DIM_W'(1);
                state_next = cfs_pkg::S_F_IK;
            end
            cfs_pkg::S_F_DEN:
            begin
                cmd.op     = cfs_pkg::DP_DIV;
                state_next = cfs_pkg::S_F_DIV_W;
            end
            cfs_pkg::S_F_DIV_W:
            begin
                if (!stat.busy)
                begin
                    cmd.ram_we   = 1'b1;
                    cmd.ram_addr = {ii, jj};
                    cmd.ram_wsel = cfs_pkg::WSEL_RES;
                    i_next       = i_reg + cfs_pkg::DIM_W'(1);
                    state_next   = cfs_pkg::S_F_I;
                end
            end
            cfs_pkg::S_F_CJ:
            begin
                if (j_reg == p)
                begin
                    state_next = cfs_pkg::S_EMIT_ZERO;
                end
                else
                begin
                    i_next     = j_reg + cfs_pkg::DIM_W'(1);
                    state_next = cfs_pkg::S_F_CI;
                end
            end
            cfs_pkg::S_F_CI:
            begin
                if (i_reg == p)
                begin
                    j_next     = j_reg + cfs_pkg::DIM_W'(1);
                    state_next = cfs_pkg::S_F_CJ;
                end
                else
                begin
                    cmd.ram_we   = 1'b1;
                    cmd.ram_addr = {jj, ii};
                    i_next       = i_reg + cfs_pkg::DIM_W'(1);
                end
            end

            cfs_pkg::S_FI:
            begin
                if (i_reg == p)
                begin
                    if (op_reg == cfs_pkg::OP_SOLVE)
                    begin
                        state_next = cfs_pkg::S_BI;
                    end
                    else if (op_reg == cfs_pkg::OP_QFORM)
                    begin
                        cmd.op     = cfs_pkg::DP_ACC_ZERO;
                        i_next     = '0;
                        state_next = cfs_pkg::S_Q_I;
                    end
                    else
                    begin
                        i_next     = '0;
                        state_next = cfs_pkg::S_EMIT_VEC;
                    end
                end
                else
                begin
                    cmd.op     = cfs_pkg::DP_ACC_VEC;
                    j_next     = '0;
                    state_next = cfs_pkg::S_FJ;
                end
            end
            cfs_pkg::S_FJ:
            begin
                if (j_reg == i_reg)
                begin
                    cmd.ram_addr = {ii, ii};
                    state_next   = cfs_pkg::S_FDEN;
                end
                else
                begin
                    cmd.ram_addr = {ii, jj};
                    state_next   = cfs_pkg::S_FJ_M;
                end
            end
            cfs_pkg::S_FJ_M:
            begin
                cmd.op     = cfs_pkg::DP_MUL_RV;
                cmd.vidx   = jj;
                state_next = cfs_pkg::S_FJ_S;
            end
            cfs_pkg::S_FJ_S:
            begin
                cmd.op     = cfs_pkg::DP_ACC_SUB;
                j_next     = j_reg + cfs_pkg::DIM_W'(1);
                state_next = cfs_pkg::S_FJ;
            end
            cfs_pkg::S_FDEN:
            begin
                cmd.op     = cfs_pkg::DP_DIV;
                state_next = cfs_pkg::S_FDIV_W;
            end
            cfs_pkg::S_FDIV_W:
            begin
                if (!stat.busy)
                begin
                    cmd.vec_we = 1'b1;
                    i_next     = i_reg + cfs_pkg::DIM_W'(1);
                    state_next = cfs_pkg::S_FI;
                end
            end

            cfs_pkg::S_BI:
            begin
                cmd.vidx = bb;
                if (i_reg == '0)
                begin
                    state_next = cfs_pkg::S_EMIT_VEC;
                end
                else
                begin
                    cmd.op     = cfs_pkg::DP_ACC_VEC;
                    j_next     = i_reg;
                    state_next = cfs_pkg::S_BJ;
                end
            end
            cfs_pkg::S_BJ:
            begin
                if (j_reg == p)
                begin
                    cmd.ram_addr = {bb, bb};
                    state_next   = cfs_pkg::S_BDEN;
                end
                else
                begin
                    cmd.ram_addr = {jj, bb};
                    state_next   = cfs_pkg::S_BJ_M;
                end
            end
            cfs_pkg::S_BJ_M:
            begin
                cmd.op     = cfs_pkg::DP_MUL_RV;
                cmd.vidx   = jj;
                state_next = cfs_pkg::S_BJ_S;
            end
            cfs_pkg::S_BJ_S:
            begin
                cmd.op     = cfs_pkg::DP_ACC_SUB;
                j_next     = j_reg + cfs_pkg::DIM_W'(1);
                state_next = cfs_pkg::S_BJ;
            end
            cfs_pkg::S_BDEN:
            begin
                cmd.op     = cfs_pkg::DP_DIV;
                state_next = cfs_pkg::S_BDIV_W;
            end
            cfs_pkg::S_BDIV_W:
            begin
                cmd.vidx = bb;
                if (!stat.busy)
                begin
                    cmd.vec_we = 1'b1;
                    i_next     = b;
                    state_next = cfs_pkg::S_BI;
                end
            end

            cfs_pkg::S_Q_I:
            begin
                if (i_reg == p)
                begin
                    state_next = cfs_pkg::S_EMIT_ACC;
                end
                else
                begin
                    cmd.op     = cfs_pkg::DP_MUL_VV;
                    state_next = cfs_pkg::S_Q_S;
                end
            end
            cfs_pkg::S_Q_S:
            begin
                cmd.op     = cfs_pkg::DP_ACC_ADD;
                i_next     = i_reg + cfs_pkg::DIM_W'(1);
                state_next = cfs_pkg::S_Q_I;
            end

            cfs_pkg::S_EMIT_ZERO:
            begin
                if (!stat.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = cfs_pkg::S_IDLE;
                end
            end
            cfs_pkg::S_EMIT_ACC:
            begin
                cmd.out_sel = cfs_pkg::OSEL_ACC;
                if (!stat.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = cfs_pkg::S_IDLE;
                end
            end
            cfs_pkg::S_EMIT_RD:
            begin
                cmd.ram_addr = {r_reg, c_reg};
                cmd.out_sel  = cfs_pkg::OSEL_RAM;
                if (!stat.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = cfs_pkg::S_IDLE;
                end
            end
            cfs_pkg::S_EMIT_VEC:
            begin
                cmd.out_sel   = cfs_pkg::OSEL_VEC;
                cmd.out_index = ii;
                cmd.out_last  = (i_reg == p - cfs_pkg::DIM_W'(1));
                if (!stat.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    i_next       = i_reg + cfs_pkg::DIM_W'(1);
                    if (i_reg == p - cfs_pkg::DIM_W'(1))
                    begin
                        state_next = cfs_pkg::S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = cfs_pkg::S_IDLE;
            end
        endcase
    end

endmodule

[hw/rtl/cholesky_factor_solve.sv]
// Cholesky factor and triangular solve engine, signed Q16.16.
// Input channel: in_valid/in_ready with operation, row_index, col_index and
// data_value. Load requests (matrix or vector element) finish as accepted,
// so loads stream back to back. Factor, solve, forward solve, quadratic form
// and read requests run to completion before the next request is taken.
// Output channel: out_valid/out_ready with result_value, result_index,
// last_of_run and status, held in an output register.
// Work is shared by one multiply-accumulate path and one iterative unit:
// each division produces one quotient bit per cycle over 48 bits, and each
// square root is computed bitwise in the same unit. A factor of order p
// costs roughly p*p/2 divisions plus p*p*p/6 product terms; a solve costs
// 2p divisions plus p*p product terms.
// A read raises out_valid after S_EMIT_RD loads the output register.
// User must write matrix_size via cfg_wr_en/cfg_wr_data while idle; unchecked.
// Reset clears the controller, the pivot flag and sets matrix_size to 8;
// matrix and vector contents are undefined until loaded.
// When the receiver stalls, the result is held and the engine waits before
// producing the next result.
module cholesky_factor_solve (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [cfs_pkg::DIM_W-1:0]         cfg_wr_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [2:0]                        operation,
    input  logic [cfs_pkg::IDX_W-1:0]         row_index,
    input  logic [cfs_pkg::IDX_W-1:0]         col_index,
    input  logic signed [cfs_pkg::DATA_W-1:0] data_value,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [cfs_pkg::DATA_W-1:0] result_value,
    output logic [cfs_pkg::IDX_W-1:0]         result_index,
    output logic                              last_of_run,
    output logic [1:0]                        status
);

    cfs_pkg::cfs_cmd_t  cmd;
    cfs_pkg::cfs_stat_t stat;

    cfs_controller u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .operation  (operation),
        .row_index  (row_index),
        .col_index  (col_index),
        .stat       (stat),
        .cmd        (cmd)
    );

    cfs_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .data_value  (data_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result_value(result_value),
        .result_index(result_index),
        .last_of_run (last_of_run),
        .status      (status)
    );

endmodule
